// ===== rtl/core/fqrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fqrs_pkg
// Shared constants, codes and control types for the reversible FIFO queue.
// ----------------------------------------------------------------------------
package fqrs_pkg;

  localparam int DEPTH  = 128;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 8;
  localparam int OCC_W  = 8;

  localparam logic signed [POS_W-1:0] NOT_FOUND = -8'sd1;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_POP     = 2'd1,
    ACT_REVERSE = 2'd2,
    ACT_FIND    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_FIND
  } state_t;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift_dn;
    logic shift_up;
  } cell_ctl_t;

  // ring control from the sequencer
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] load_idx;
    logic             shift_dn;
    logic             shift_up;
  } ring_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/fifo_queue_with_reverse_and_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_reverse_and_search
// Bounded FIFO of signed words with order reversal and front-to-back search.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result, shown for one cycle with out_valid, and the receiver
// cannot stall it. The words sit in a ring of DEPTH cells that rotates by one
// word per cycle. In normal order the front is the first cell, in reversed
// order the last cell. Push and pop give their result on the next cycle.
// Reverse gives its result on the next cycle, then keeps busy high while the
// ring realigns, rotating by occupancy words (normal to reversed) or DEPTH -
// occupancy words (back to normal); none on an empty queue. Find walks the
// whole ring once, one word per cycle, and gives its result when the walk
// ends; busy is low again on the cycle the result shows.
// ----------------------------------------------------------------------------
module fifo_queue_with_reverse_and_search (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_action,
  input  wire logic signed [fqrs_pkg::DATA_W-1:0]  in_value,
  output logic                                     out_valid,
  output logic signed [fqrs_pkg::DATA_W-1:0]       out_popped_value,
  output logic signed [fqrs_pkg::POS_W-1:0]        out_found_position,
  output logic [fqrs_pkg::OCC_W-1:0]               out_occupancy,
  output logic                                     out_is_full,
  output logic                                     out_is_empty,
  output logic [1:0]                               out_error_code
);

  localparam logic [fqrs_pkg::CNT_W-1:0] CNT_DEPTH = fqrs_pkg::CNT_W'(fqrs_pkg::DEPTH);
  localparam logic [fqrs_pkg::IDX_W-1:0] IDX_LAST  = fqrs_pkg::IDX_W'(fqrs_pkg::DEPTH - 1);

  fqrs_pkg::state_t state_r, state_nxt;

  logic [fqrs_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                               rev_r, rev_nxt;
  logic [fqrs_pkg::CNT_W-1:0]         rot_cnt_r, rot_cnt_nxt;
  logic [fqrs_pkg::IDX_W-1:0]         step_r, step_nxt;
  logic signed [fqrs_pkg::DATA_W-1:0] key_r, key_nxt;
  logic                               hit_r, hit_nxt;
  logic [fqrs_pkg::IDX_W-1:0]         hit_pos_r, hit_pos_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [fqrs_pkg::DATA_W-1:0] out_pop_r, out_pop_nxt;
  logic signed [fqrs_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [fqrs_pkg::CNT_W-1:0]         out_cnt_r, out_cnt_nxt;
  fqrs_pkg::err_t                     out_err_r, out_err_nxt;

  fqrs_pkg::ring_ctl_t                ring_ctl;
  logic signed [fqrs_pkg::DATA_W-1:0] first_word, last_word, tap_word;
  logic                               accept;
  logic                               match;
  logic                               find_done;
  logic                               rot_done;
  logic [fqrs_pkg::CNT_W-1:0]         rot_amt;
  fqrs_pkg::action_t                  act;

  assign busy      = (state_r != fqrs_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign act       = fqrs_pkg::action_t'(in_action);
  assign tap_word  = rev_r ? last_word : first_word;
  assign match     = !hit_r && (fqrs_pkg::CNT_W'(step_r) < count_r) && (tap_word == key_r);
  assign find_done = (step_r == IDX_LAST);
  assign rot_done  = (rot_cnt_r == fqrs_pkg::CNT_W'(1));

  always_comb begin
    if (count_r == '0) begin
      rot_amt = '0;
    end else if (rev_r) begin
      rot_amt = CNT_DEPTH - count_r;
    end else begin
      rot_amt = count_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fqrs_pkg::ST_IDLE: begin
        if (accept && act == fqrs_pkg::ACT_FIND) begin
          state_nxt = fqrs_pkg::ST_FIND;
        end else if (accept && act == fqrs_pkg::ACT_REVERSE && rot_amt != '0) begin
          state_nxt = fqrs_pkg::ST_ROTATE;
        end
      end
      fqrs_pkg::ST_ROTATE: begin
        if (rot_done) begin
          state_nxt = fqrs_pkg::ST_IDLE;
        end
      end
      fqrs_pkg::ST_FIND: begin
        if (find_done) begin
          state_nxt = fqrs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fqrs_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    rot_cnt_nxt   = rot_cnt_r;
    step_nxt      = step_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    hit_pos_nxt   = hit_pos_r;
    out_valid_nxt = 1'b0;
    out_pop_nxt   = out_pop_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    out_err_nxt   = out_err_r;
    ring_ctl      = '0;

    unique case (state_r)
      fqrs_pkg::ST_IDLE: begin
        if (accept) begin
          out_pop_nxt = '0;
          out_pos_nxt = '0;
          out_err_nxt = fqrs_pkg::ERR_OK;
          unique case (act)
            fqrs_pkg::ACT_PUSH: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_DEPTH) begin
                out_err_nxt = fqrs_pkg::ERR_FULL;
              end else begin
                ring_ctl.load     = 1'b1;
                ring_ctl.load_idx = rev_r ? (IDX_LAST - count_r[fqrs_pkg::IDX_W-1:0])
                                          : count_r[fqrs_pkg::IDX_W-1:0];
                count_nxt         = count_r + fqrs_pkg::CNT_W'(1);
              end
            end
            fqrs_pkg::ACT_POP: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                out_err_nxt = fqrs_pkg::ERR_EMPTY;
              end else begin
                out_pop_nxt       = tap_word;
                ring_ctl.shift_dn = !rev_r;
                ring_ctl.shift_up = rev_r;
                count_nxt         = count_r - fqrs_pkg::CNT_W'(1);
              end
            end
            fqrs_pkg::ACT_REVERSE: begin
              out_valid_nxt = 1'b1;
              rev_nxt       = !rev_r;
              rot_cnt_nxt   = rot_amt;
            end
            fqrs_pkg::ACT_FIND: begin
              key_nxt  = in_value;
              step_nxt = '0;
              hit_nxt  = 1'b0;
            end
            default: ;
          endcase
          out_cnt_nxt = count_nxt;
        end
      end
      fqrs_pkg::ST_ROTATE: begin
        // front moves to the other end of the ring
        ring_ctl.shift_dn = 1'b1;
        rot_cnt_nxt       = rot_cnt_r - fqrs_pkg::CNT_W'(1);
      end
      fqrs_pkg::ST_FIND: begin
        ring_ctl.shift_dn = !rev_r;
        ring_ctl.shift_up = rev_r;
        step_nxt          = step_r + fqrs_pkg::IDX_W'(1);
        if (match) begin
          hit_nxt     = 1'b1;
          hit_pos_nxt = step_r;
        end
        if (find_done) begin
          out_valid_nxt = 1'b1;
          out_pop_nxt   = '0;
          out_cnt_nxt   = count_r;
          out_err_nxt   = fqrs_pkg::ERR_OK;
          if (hit_r) begin
            out_pos_nxt = fqrs_pkg::POS_W'(hit_pos_r);
          end else if (match) begin
            out_pos_nxt = fqrs_pkg::POS_W'(step_r);
          end else begin
            out_pos_nxt = fqrs_pkg::NOT_FOUND;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqrs_pkg::ST_IDLE;
      count_r     <= '0;
      rev_r       <= 1'b0;
      rot_cnt_r   <= '0;
      step_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      rot_cnt_r   <= rot_cnt_nxt;
      step_r      <= step_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    hit_pos_r <= hit_pos_nxt;
    out_pop_r <= out_pop_nxt;
    out_pos_r <= out_pos_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_err_r <= out_err_nxt;
  end

  fqrs_ring u_ring (
    .clk        (clk),
    .ctl        (ring_ctl),
    .load_data  (in_value),
    .first_word (first_word),
    .last_word  (last_word)
  );

  assign out_valid          = out_valid_r;
  assign out_popped_value   = out_pop_r;
  assign out_found_position = out_pos_r;
  assign out_occupancy      = fqrs_pkg::OCC_W'(out_cnt_r);
  assign out_is_full        = (out_cnt_r == CNT_DEPTH);
  assign out_is_empty       = (out_cnt_r == '0);
  assign out_error_code     = out_err_r;

endmodule
`default_nettype wire

// ===== rtl/core/fqrs_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fqrs_cell
// One storage cell of the ring: holds a word, loads a new one, or takes the
// word of its upper or lower neighbor.
// ----------------------------------------------------------------------------
module fqrs_cell (
  input  wire logic                                clk,
  input  wire fqrs_pkg::cell_ctl_t                 ctl,
  input  wire logic signed [fqrs_pkg::DATA_W-1:0]  load_data,
  input  wire logic signed [fqrs_pkg::DATA_W-1:0]  from_hi,
  input  wire logic signed [fqrs_pkg::DATA_W-1:0]  from_lo,
  output logic signed [fqrs_pkg::DATA_W-1:0]       data
);

  logic signed [fqrs_pkg::DATA_W-1:0] data_r;
  logic signed [fqrs_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    if (ctl.load) begin
      data_nxt = load_data;
    end else if (ctl.shift_dn) begin
      data_nxt = from_hi;
    end else if (ctl.shift_up) begin
      data_nxt = from_lo;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

// ===== rtl/core/fqrs_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fqrs_ring
// Circular chain of DEPTH cells. Shifts down or up by one word per cycle and
// exposes the words in the first and last cells.
// ----------------------------------------------------------------------------
module fqrs_ring (
  input  wire logic                                clk,
  input  wire fqrs_pkg::ring_ctl_t                 ctl,
  input  wire logic signed [fqrs_pkg::DATA_W-1:0]  load_data,
  output logic signed [fqrs_pkg::DATA_W-1:0]       first_word,
  output logic signed [fqrs_pkg::DATA_W-1:0]       last_word
);

  logic signed [fqrs_pkg::DATA_W-1:0] cell_data [fqrs_pkg::DEPTH];

  for (genvar i = 0; i < fqrs_pkg::DEPTH; i++) begin : g_cell
    localparam int HI = (i + 1) % fqrs_pkg::DEPTH;
    localparam int LO = (i + fqrs_pkg::DEPTH - 1) % fqrs_pkg::DEPTH;

    fqrs_pkg::cell_ctl_t cctl;

    always_comb begin
      cctl.load     = ctl.load && (ctl.load_idx == fqrs_pkg::IDX_W'(i));
      cctl.shift_dn = ctl.shift_dn;
      cctl.shift_up = ctl.shift_up;
    end

    fqrs_cell u_cell (
      .clk       (clk),
      .ctl       (cctl),
      .load_data (load_data),
      .from_hi   (cell_data[HI]),
      .from_lo   (cell_data[LO]),
      .data      (cell_data[i])
    );
  end

  assign first_word = cell_data[0];
  assign last_word  = cell_data[fqrs_pkg::DEPTH-1];

endmodule
`default_nettype wire
